// File: design/dqp_pkg.sv
// Shared types and constants for the dotted-quad IPv4 parser.
package dqp_pkg;

	// Character codes used by the classifier.
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// Octet limits and radix.
	localparam logic [8:0] OCTET_MAX = 9'd255;
	localparam logic [8:0] OCTET_SAT = 9'd256;
	localparam logic [3:0] RADIX     = 4'd10;

	localparam logic [1:0] LAST_FIELD = 2'd3;

	// Classified character as the back end sees it.
	typedef struct packed {
		logic       is_space;  // space, tab, LF, VT, FF, CR
		logic       is_sign;   // '+' or '-'
		logic       is_minus;  // '-'
		logic       is_digit;
		logic [3:0] digit;
		logic       is_dot;
		logic       is_term;   // NUL, space or tab
	} char_class_t;

	// A NUL byte, appended after the last character of a string.
	localparam char_class_t NUL_CLASS = '{
		is_space: 1'b0, is_sign: 1'b0, is_minus: 1'b0, is_digit: 1'b0,
		digit: 4'd0, is_dot: 1'b0, is_term: 1'b1
	};

	typedef struct packed {
		char_class_t cls;
		logic        last;
	} queue_word_t;

	// Write side of the queue between front and back end.
	typedef struct packed {
		logic        push;
		queue_word_t word;
	} queue_wr_t;

	// Read side of the queue.
	typedef struct packed {
		logic        avail;
		queue_word_t word;
	} queue_rd_t;

	typedef enum logic [1:0] {
		PH_START,
		PH_SPACE,
		PH_SIGN,
		PH_DIGITS
	} phase_t;

	typedef enum logic [1:0] {
		OUT_PENDING,
		OUT_PASS,
		OUT_FAIL
	} outcome_t;

	typedef struct packed {
		logic [1:0]  field_index;
		phase_t      phase;
		logic [8:0]  octet;
		logic        negative;
		logic        empty_ok;
		logic [23:0] hold;
		outcome_t    outcome;
	} parse_st_t;

	localparam parse_st_t PARSE_RESET = '{
		field_index: 2'd0, phase: PH_START, octet: 9'd0, negative: 1'b0,
		empty_ok: 1'b0, hold: 24'd0, outcome: OUT_PENDING
	};

endpackage

// File: design/dqp_front.sv
// Front end: accepts characters, classifies them and writes them to the queue.
module dqp_front import dqp_pkg::*; (
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  char_code,
	input  logic        last,
	input  logic        queue_full,
	output queue_wr_t   queue_wr
);

	function automatic char_class_t classify(input logic [7:0] c);
		char_class_t k;
		k.is_space = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
		k.is_sign  = (c == CH_PLUS) || (c == CH_MINUS);
		k.is_minus = (c == CH_MINUS);
		k.is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
		k.digit    = 4'(c - CH_ZERO);
		k.is_dot   = (c == CH_DOT);
		k.is_term  = (c == CH_NUL) || (c == CH_SPACE) || (c == CH_TAB);
		return k;
	endfunction

	assign in_stall            = queue_full;
	assign queue_wr.push       = in_valid && !queue_full;
	assign queue_wr.word.cls   = classify(char_code);
	assign queue_wr.word.last  = last;

endmodule

// File: design/dqp_queue.sv
// Small register queue that decouples the front end from the back end.
module dqp_queue import dqp_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  queue_wr_t queue_wr,
	output logic      full,
	output queue_rd_t queue_rd,
	input  logic      pop
);

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	queue_word_t        mem_q [DEPTH];
	logic [IDX_W-1:0]   wr_ptr_q;
	logic [IDX_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	function automatic logic [IDX_W-1:0] bump(input logic [IDX_W-1:0] p);
		return (p == IDX_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full           = (count_q == CNT_W'(DEPTH));
	assign queue_rd.avail = (count_q != '0);
	assign queue_rd.word  = mem_q[rd_ptr_q];
	assign do_push        = queue_wr.push;
	assign do_pop         = pop && queue_rd.avail;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= queue_wr.word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: design/dqp_back.sv
// Back end: field parser state machine and the registered result stage.
module dqp_back import dqp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  queue_rd_t   queue_rd,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        ok,
	output logic [31:0] address
);

	parse_st_t   state_q;
	parse_st_t   after_char;
	parse_st_t   after_nul;
	parse_st_t   state_d;
	logic        out_valid_q;
	logic        ok_q;
	logic [31:0] address_q;
	logic        res_ok;
	logic [31:0] res_address;
	logic        slot_free;

	function automatic parse_st_t accumulate(input parse_st_t s, input logic [3:0] d);
		parse_st_t  n;
		logic [11:0] v;
		n = s;
		v = 12'(s.octet) * 12'(RADIX) + 12'(d);
		n.octet = (v > 12'(OCTET_SAT)) ? OCTET_SAT : v[8:0];
		n.phase = PH_DIGITS;
		return n;
	endfunction

	function automatic parse_st_t close_field(input parse_st_t s, input logic had_digits,
			input char_class_t k);
		parse_st_t n;
		logic      delim;
		logic      bad;
		n   = s;
		bad = 1'b0;
		if (had_digits) begin
			bad   = (s.octet > OCTET_MAX) || (s.negative && s.octet != '0);
			delim = (s.field_index != LAST_FIELD) ? k.is_dot : k.is_term;
		end else begin
			n.octet = '0;
			delim   = s.empty_ok;
		end
		if (bad || !delim) begin
			n.outcome = OUT_FAIL;
		end else if (s.field_index != LAST_FIELD) begin
			n.hold        = {s.hold[15:0], n.octet[7:0]};
			n.field_index = s.field_index + 1'b1;
			n.phase       = PH_START;
			n.octet       = '0;
			n.negative    = 1'b0;
			n.empty_ok    = 1'b0;
		end else begin
			n.outcome = OUT_PASS;
		end
		return n;
	endfunction

	function automatic parse_st_t feed(input parse_st_t s, input char_class_t k);
		parse_st_t n;
		n = s;
		if (s.outcome == OUT_PENDING) begin
			unique case (s.phase)
				PH_START, PH_SPACE: begin
					if (s.phase == PH_START) begin
						n.empty_ok = (s.field_index != LAST_FIELD) ? k.is_dot : k.is_term;
					end
					if (k.is_space) begin
						n.phase = PH_SPACE;
					end else if (k.is_sign) begin
						n.negative = k.is_minus;
						n.phase    = PH_SIGN;
					end else if (k.is_digit) begin
						n = accumulate(n, k.digit);
					end else begin
						n = close_field(n, 1'b0, k);
					end
				end
				PH_SIGN: begin
					n = k.is_digit ? accumulate(n, k.digit) : close_field(n, 1'b0, k);
				end
				PH_DIGITS: begin
					n = k.is_digit ? accumulate(n, k.digit) : close_field(n, 1'b1, k);
				end
				default: n.outcome = OUT_FAIL;
			endcase
		end
		return n;
	endfunction

	// A last character may only leave when the result register can take it.
	assign slot_free = !out_valid_q || !out_stall;
	assign pop       = queue_rd.avail && (!queue_rd.word.last || slot_free);

	// Next state.
	always_comb begin
		after_char = feed(state_q, queue_rd.word.cls);
		after_nul  = feed(after_char, NUL_CLASS);
		state_d    = state_q;
		if (pop) begin
			state_d = queue_rd.word.last ? PARSE_RESET : after_char;
		end
	end

	// Result of a string that ends with the current character.
	always_comb begin
		res_ok      = (after_nul.outcome == OUT_PASS);
		res_address = res_ok ? {after_nul.hold, after_nul.octet[7:0]} : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= PARSE_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pop && queue_rd.word.last) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && queue_rd.word.last) begin
			ok_q      <= res_ok;
			address_q <= res_address;
		end
	end

	assign out_valid = out_valid_q;
	assign ok        = ok_q;
	assign address   = address_q;

endmodule

// File: design/dotted_quad_ipv4_parser.sv
// Top level of the streaming dotted-quad IPv4 address parser.
//
//   Channel | Handshake           | Payload          | Word
//   --------+---------------------+------------------+------------------------------
//   input   | in_valid, in_stall  | char_code, last  | one character of the string
//   output  | out_valid, out_stall| ok, address      | verdict for one whole string
//
// One word is taken every cycle unless in_stall is raised; the parser updates its
// field state for one character per cycle while the queue holds one and no
// stalled result holds back a last character, a multiply-by-ten accumulate
// being the longest path. A last character is written to the queue; the parser
// then reads it and registers the verdict in the result stage. Reset (arst_n
// low) empties the queue, clears the parser state and drops out_valid. A stall
// on the output holds the result; the queue of QUEUE_DEPTH words absorbs input
// until it fills, and only then is in_stall raised.
//
// The front end sorts each character into classes (space, sign, digit,
// dot, terminator) and writes it to the queue. The back end runs the field
// state machine; on the last character it also applies the implied NUL that
// ends the string, registers the verdict and returns to its reset state.
module dotted_quad_ipv4_parser import dqp_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  char_code,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        ok,
	output logic [31:0] address
);

	queue_wr_t queue_wr;
	queue_rd_t queue_rd;
	logic      queue_full;
	logic      queue_pop;

	dqp_front u_front (
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.char_code  (char_code),
		.last       (last),
		.queue_full (queue_full),
		.queue_wr   (queue_wr)
	);

	dqp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.queue_wr (queue_wr),
		.full     (queue_full),
		.queue_rd (queue_rd),
		.pop      (queue_pop)
	);

	dqp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.queue_rd  (queue_rd),
		.pop       (queue_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.ok        (ok),
		.address   (address)
	);

endmodule

// File: design/dqp_checker.sv
// Port-level checks for the dotted-quad IPv4 parser, bound to its top level.
module dqp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        last,
	input logic        out_valid,
	input logic        out_stall,
	input logic        ok,
	input logic [31:0] address
);

	// Strings whose last character was taken but whose verdict is not yet out.
	logic [7:0] open_q;
	logic       last_in;
	logic       word_out;

	assign last_in  = in_valid && !in_stall && last;
	assign word_out = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
		end else begin
			open_q <= open_q + 8'(last_in) - 8'(word_out);
		end
	end

	a_out_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result word dropped while stalled");

	a_payload_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(ok) && $stable(address))
		else $error("result payload changed while stalled");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !ok |-> address == 32'd0)
		else $error("failed parse carries a nonzero address");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> open_q != 8'd0)
		else $error("result word without a finished string");

endmodule

bind dotted_quad_ipv4_parser dqp_checker u_dqp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.last      (last),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.ok        (ok),
	.address   (address)
);
